[rtl/core/itd_pkg.sv]
// itd_pkg: shared constants, register indexes and widths for the tap detector
// no dependencies; imported by every module of the block
`default_nettype none
package itd_pkg;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned AX_W = 16;
  localparam int unsigned STR_W = 19;

  localparam logic [15:0] RESET_START_LEVEL = 16'd450;
  localparam logic [15:0] RESET_CONFIRM_LEVEL = 16'd900;
  localparam logic [15:0] RESET_CONFIRM_RISE = 16'd320;
  localparam logic [15:0] RESET_CONFIRM_ACCEL = 16'd120;
  localparam logic [15:0] RESET_DT_WINDOW = 16'd650;
  localparam logic [15:0] RESET_BASELINE = 16'd1000;
  localparam logic [18:0] RELEASE_LEVEL = 19'd450;
  localparam logic [15:0] TAP_MAX_MS = 16'd90;
  localparam logic [15:0] TRACK_LIMIT = 16'd120;
  localparam int unsigned ROOT_STEPS = 16;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } tap_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFF_X         = 8'd0,
    REG_OFF_Y         = 8'd1,
    REG_OFF_Z         = 8'd2,
    REG_START_LEVEL   = 8'd3,
    REG_CONFIRM_LEVEL = 8'd4,
    REG_CONFIRM_RISE  = 8'd5,
    REG_CONFIRM_ACCEL = 8'd6,
    REG_DT_WINDOW     = 8'd7
  } cfg_reg_t;

  // thresholds the tap state machine reads
  typedef struct packed {
    logic [15:0] start_level;
    logic [15:0] confirm_level;
    logic [15:0] confirm_rise;
    logic [15:0] confirm_accel;
    logic [15:0] dt_window;
  } tap_cfg_t;
endpackage
`default_nettype wire

[rtl/core/itd_front.sv]
// itd_front: offset removal, squares, saturating sum and iterative square root
// depends on itd_pkg; pushes {enable, time, accel, gyro magnitude} toward the queue
`default_nettype none
module itd_front import itd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned QW = 33 + TIME_WIDTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [15:0]     gyro_x,
  input  wire logic [15:0]     gyro_y,
  input  wire logic [15:0]     gyro_z,
  input  wire logic [15:0]     accel,
  input  wire logic [TIME_WIDTH-1:0] time_ms,
  input  wire logic            enable,
  input  wire logic [15:0]     off_x,
  input  wire logic [15:0]     off_y,
  input  wire logic [15:0]     off_z,
  output logic                 push,
  output logic [QW-1:0]        push_data,
  input  wire logic            q_full
);
  typedef enum logic [2:0] {S_IDLE, S_SQUARE, S_SUM, S_ROOT, S_PUSH} fstate_t;

  fstate_t state_r;
  logic [15:0] mx_r, my_r, mz_r;
  logic [31:0] sqx_r, sqy_r, sqz_r;
  logic [31:0] rem_r, root_r, bit_r;
  logic [3:0] step_r;
  logic [15:0] accel_r;
  logic [TIME_WIDTH-1:0] time_r;
  logic en_r;

  logic [15:0] dx, dy, dz;
  logic [33:0] sum;
  logic [31:0] trial;

  always_comb begin
    dx = gyro_x - off_x;
    dy = gyro_y - off_y;
    dz = gyro_z - off_z;
    sum = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};
    trial = root_r + bit_r;
  end

  assign in_ready = (state_r == S_IDLE);
  assign push = (state_r == S_PUSH) && !q_full;
  assign push_data = {en_r, time_r, accel_r, root_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mx_r <= dx[15] ? (~dx + 16'd1) : dx;
            my_r <= dy[15] ? (~dy + 16'd1) : dy;
            mz_r <= dz[15] ? (~dz + 16'd1) : dz;
            accel_r <= accel;
            time_r <= time_ms;
            en_r <= enable;
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sqx_r <= mx_r * mx_r;
          sqy_r <= my_r * my_r;
          sqz_r <= mz_r * mz_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          rem_r <= (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
          root_r <= '0;
          bit_r <= 32'h4000_0000;
          step_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          step_r <= step_r + 4'd1;
          if (step_r == 4'(ROOT_STEPS - 1)) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/itd_queue.sv]
// itd_queue: two-entry queue between the magnitude front end and the tap back end
// depends on itd_pkg for TIME_WIDTH_DEF, the default width behind QW
`default_nettype none
module itd_queue import itd_pkg::*; #(
  parameter int unsigned QW = 33 + TIME_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [QW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic [QW-1:0]      pop_data,
  output logic               not_empty
);
  logic [QW-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/core/itd_back.sv]
// itd_back: accel baseline tracking, strength and the tap state machine
// depends on itd_pkg; pops the queue and holds the result register
`default_nettype none
module itd_back import itd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned QW = 33 + TIME_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  wire logic [QW-1:0] q_data,
  output logic               pop,
  input  wire tap_cfg_t      cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         tap_event,
  output logic               tap_busy,
  output logic [STR_W-1:0]   strength,
  output logic [15:0]        gyro_mag,
  output logic [15:0]        dyn_accel
);
  logic [15:0] base_r, prev_r, pk_str_r, pk_acc_r, pk_rise_r;
  logic cand_r, rej_r, await_r;
  logic [TIME_WIDTH-1:0] cstart_r, lconf_r;
  logic out_valid_r;
  logic [1:0] ev_r;
  logic busy_r;
  logic [STR_W-1:0] str_r;
  logic [15:0] gmag_r, dyn_r;

  logic [15:0] base_nxt, prev_nxt, pk_str_nxt, pk_acc_nxt, pk_rise_nxt;
  logic cand_nxt, rej_nxt, await_nxt;
  logic [TIME_WIDTH-1:0] cstart_nxt, lconf_nxt;
  logic [1:0] ev_nxt;

  logic [15:0] gm, acc, dyn, s16, rise;
  logic [TIME_WIDTH-1:0] now, d_max, d_win;
  logic en, released, by_accel, by_sharp, timed_out, win_le, win_over;
  logic [STR_W-1:0] str;
  logic [16:0] up_diff;

  assign pop = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign tap_event = ev_r;
  assign tap_busy = busy_r;
  assign strength = str_r;
  assign gyro_mag = gmag_r;
  assign dyn_accel = dyn_r;

  always_comb begin
    gm = q_data[15:0];
    acc = q_data[31:16];
    now = q_data[32 +: TIME_WIDTH];
    en = q_data[QW-1];
    dyn = (acc > base_r) ? (acc - base_r) : (base_r - acc);
    base_nxt = base_r;
    if (dyn < TRACK_LIMIT) begin
      if (acc >= base_r) begin
        base_nxt = base_r + {5'd0, dyn[15:5]};
      end else begin
        up_diff = {1'b0, dyn} + 17'd31;
        base_nxt = base_r - {4'd0, up_diff[16:5]};
      end
    end
    up_diff = {1'b0, dyn} + 17'd31;
    str = {3'd0, gm} + {1'b0, dyn, 2'b00};
    s16 = (str[STR_W-1:16] != '0) ? 16'hFFFF : str[15:0];
    rise = (s16 > prev_r) ? (s16 - prev_r) : 16'd0;
    released = (str <= RELEASE_LEVEL);
    // wrap-safe time differences, sign in the top bit
    d_max = now - cstart_r - TIME_WIDTH'(TAP_MAX_MS);
    d_win = now - lconf_r - TIME_WIDTH'(cfg.dt_window);
    timed_out = !d_max[TIME_WIDTH-1];
    win_over = !d_win[TIME_WIDTH-1];
    win_le = (d_win == '0) || d_win[TIME_WIDTH-1];

    prev_nxt = prev_r;
    pk_str_nxt = pk_str_r;
    pk_acc_nxt = pk_acc_r;
    pk_rise_nxt = pk_rise_r;
    cand_nxt = cand_r;
    rej_nxt = rej_r;
    await_nxt = await_r;
    cstart_nxt = cstart_r;
    lconf_nxt = lconf_r;
    ev_nxt = EV_NONE;
    by_accel = 1'b0;
    by_sharp = 1'b0;

    if (!en) begin
      cand_nxt = 1'b0;
      rej_nxt = 1'b0;
      await_nxt = 1'b0;
      pk_str_nxt = '0;
      pk_acc_nxt = '0;
      pk_rise_nxt = '0;
      prev_nxt = '0;
    end else begin
      prev_nxt = s16;
      if (rej_r) begin
        if (released) rej_nxt = 1'b0;
      end else if (cand_r) begin
        if (s16 > pk_str_r) pk_str_nxt = s16;
        if (dyn > pk_acc_r) pk_acc_nxt = dyn;
        if (rise > pk_rise_r) pk_rise_nxt = rise;
        by_accel = pk_acc_nxt >= cfg.confirm_accel;
        by_sharp = (pk_str_nxt >= cfg.confirm_level) && (pk_rise_nxt >= cfg.confirm_rise);
        if (released) begin
          cand_nxt = 1'b0;
          if (by_accel || by_sharp) begin
            lconf_nxt = now;
            if (await_r && win_le) begin
              await_nxt = 1'b0;
              ev_nxt = EV_DOUBLE;
            end else begin
              await_nxt = 1'b1;
            end
          end
        end else if (timed_out) begin
          cand_nxt = 1'b0;
          await_nxt = 1'b0;
          rej_nxt = 1'b1;
        end
      end else if (await_r && win_over) begin
        await_nxt = 1'b0;
        ev_nxt = EV_SINGLE;
      end else if (str >= {3'd0, cfg.start_level}) begin
        cand_nxt = 1'b1;
        cstart_nxt = now;
        pk_str_nxt = s16;
        pk_acc_nxt = dyn;
        pk_rise_nxt = rise;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= RESET_BASELINE;
      prev_r <= '0;
      pk_str_r <= '0;
      pk_acc_r <= '0;
      pk_rise_r <= '0;
      cand_r <= 1'b0;
      rej_r <= 1'b0;
      await_r <= 1'b0;
      cstart_r <= '0;
      lconf_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        base_r <= base_nxt;
        prev_r <= prev_nxt;
        pk_str_r <= pk_str_nxt;
        pk_acc_r <= pk_acc_nxt;
        pk_rise_r <= pk_rise_nxt;
        cand_r <= cand_nxt;
        rej_r <= rej_nxt;
        await_r <= await_nxt;
        cstart_r <= cstart_nxt;
        lconf_r <= lconf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r <= ev_nxt;
      busy_r <= en && (cand_nxt || await_nxt);
      str_r <= str;
      gmag_r <= gm;
      dyn_r <= dyn;
    end
  end
endmodule
`default_nettype wire

[rtl/core/imu_tap_double_tap_detector.sv]
// imu_tap_double_tap_detector: top level, config registers, front end, queue, back end
// depends on itd_pkg, itd_front, itd_queue and itd_back
//
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tdata gyro x,y,z, accel, time; tuser enable
// out_      out  out_tvalid/out_tready  tdata event, busy, strength, gyro mag, dyn accel
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// an item passes through the front end in order: capture, square, sum, ROOT_STEPS root
// iterations of its single root unit and the push into the queue
// the back end retires one queued item per cycle into the output register unless
// the output stalls; reset is synchronous; a stalled output fills the queue, then
// the front end waits; config writes always complete in the cycle they are offered
`default_nettype none
module imu_tap_double_tap_detector import itd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // gyro_x, gyro_y, gyro_z, accel_magnitude, time_ms, zero fill
  input  wire logic [((64 + TIME_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // tap_enable
  input  wire logic [0:0] in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // tap_event, tap_busy, motion_strength, gyro_magnitude, dynamic_accel, zero fill
  output logic [55:0] out_tdata,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned QW = 33 + TIME_WIDTH;

  logic [15:0] off_x_r, off_y_r, off_z_r;
  tap_cfg_t tcfg_r;
  logic push, q_full, pop, q_ne;
  logic [QW-1:0] push_data, pop_data;
  logic [1:0] ev;
  logic busy;
  logic [STR_W-1:0] str;
  logic [15:0] gmag, dyn;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      tcfg_r.start_level <= RESET_START_LEVEL;
      tcfg_r.confirm_level <= RESET_CONFIRM_LEVEL;
      tcfg_r.confirm_rise <= RESET_CONFIRM_RISE;
      tcfg_r.confirm_accel <= RESET_CONFIRM_ACCEL;
      tcfg_r.dt_window <= RESET_DT_WINDOW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFF_X:         off_x_r <= cfg_data;
        REG_OFF_Y:         off_y_r <= cfg_data;
        REG_OFF_Z:         off_z_r <= cfg_data;
        REG_START_LEVEL:   tcfg_r.start_level <= cfg_data;
        REG_CONFIRM_LEVEL: tcfg_r.confirm_level <= cfg_data;
        REG_CONFIRM_RISE:  tcfg_r.confirm_rise <= cfg_data;
        REG_CONFIRM_ACCEL: tcfg_r.confirm_accel <= cfg_data;
        REG_DT_WINDOW:     tcfg_r.dt_window <= cfg_data;
        default: ;
      endcase
    end
  end

  itd_front #(.TIME_WIDTH(TIME_WIDTH), .QW(QW)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .gyro_x(in_tdata[15:0]), .gyro_y(in_tdata[31:16]), .gyro_z(in_tdata[47:32]),
    .accel(in_tdata[63:48]), .time_ms(in_tdata[64 +: TIME_WIDTH]),
    .enable(in_tuser[0]),
    .off_x(off_x_r), .off_y(off_y_r), .off_z(off_z_r),
    .push, .push_data, .q_full
  );

  itd_queue #(.QW(QW)) u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .pop_data, .not_empty(q_ne)
  );

  itd_back #(.TIME_WIDTH(TIME_WIDTH), .QW(QW)) u_back (
    .clk, .rst_n, .q_not_empty(q_ne), .q_data(pop_data), .pop,
    .cfg(tcfg_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .tap_event(ev), .tap_busy(busy), .strength(str), .gyro_mag(gmag), .dyn_accel(dyn)
  );

  assign out_tdata = {2'b00, dyn, gmag, str, busy, ev};
endmodule
`default_nettype wire

[rtl/core/itd_checker.sv]
// itd_checker: port-level checks on the tap detector's result stream
// depends on itd_pkg; bound to imu_tap_double_tap_detector below
`default_nettype none
module itd_checker import itd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad tap event code");

  // a reported tap closes every open wait
  a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> !out_tdata[2])
    else $error("busy set with a tap event");

  a_strength: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:3] ==
      {3'd0, out_tdata[37:22]} + {1'b0, out_tdata[53:38], 2'b00})
    else $error("strength does not match its parts");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
endmodule

bind imu_tap_double_tap_detector itd_checker u_itd_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire

[dv/testbench.sv]
// self-checking bench for imu_tap_double_tap_detector: queued samples, tap bursts and noise
// depends on itd_pkg and the detector rtl; carries its own tap predictor
`default_nettype none
module testbench import itd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [15:0] gx, gy, gz, acc;
    logic [31:0] tms;
    logic        en;
  } sample_t;

  typedef struct {
    tap_ev_t     ev;
    logic        busy;
    logic [18:0] strength;
    logic [15:0] gmag;
    logic [15:0] dyn;
  } tap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;   // gyro_x, gyro_y, gyro_z, accel_magnitude, time_ms
  logic [0:0] in_tuser = '0;    // tap_enable
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;       // tap_event, tap_busy, motion_strength, gyro_magnitude, dyn accel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  imu_tap_double_tap_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] regs [8];
  logic [15:0] baseline;
  logic [15:0] prev_str, pk_str, pk_acc, pk_rise;
  logic        cand, rejected, awaiting;
  logic [31:0] cand_t, confirm_t;

  sample_t     sample_q[$];
  tap_result_t tap_exp_q[$];
  sample_t     cur;
  int          acc_cnt = 0, seen_cnt = 0;
  int          cycle = 0, errs = 0, n_items = 0;
  logic [31:0] t_now;
  logic        calm_lo, calm_hi;

  function automatic logic [33:0] axis_sq(logic [15:0] raw, logic [15:0] off);
    logic [15:0] v;
    logic [16:0] m;
    v = raw - off;
    m = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
    return m * m;
  endfunction

  function automatic logic [15:0] isqrt(logic [31:0] v);
    logic [31:0] b, r;
    b = 32'h4000_0000;
    r = '0;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[15:0];
  endfunction

  // sign of (now - ref - add) modulo 2^32
  function automatic logic t_neg(logic [31:0] now, logic [31:0] ref_t, logic [31:0] add);
    logic [31:0] d;
    d = now - ref_t - add;
    return d[31];
  endfunction

  function automatic void clear_tap();
    cand = 0; rejected = 0; awaiting = 0;
    pk_str = 0; pk_acc = 0; pk_rise = 0; prev_str = 0;
  endfunction

  function automatic tap_ev_t run_tap(logic [18:0] str, logic [15:0] dyn, logic [31:0] now);
    logic [15:0] s16, rise;
    logic        by_acc, by_sharp, in_win;
    logic [31:0] d;
    s16 = (str > 19'd65535) ? 16'hFFFF : str[15:0];
    rise = (s16 > prev_str) ? s16 - prev_str : 16'd0;
    prev_str = s16;
    if (rejected) begin
      if (str <= RELEASE_LEVEL) rejected = 0;
      return EV_NONE;
    end
    if (cand) begin
      if (s16 > pk_str) pk_str = s16;
      if (dyn > pk_acc) pk_acc = dyn;
      if (rise > pk_rise) pk_rise = rise;
      if (str <= RELEASE_LEVEL) begin
        cand = 0;
        by_acc = pk_acc >= regs[REG_CONFIRM_ACCEL];
        by_sharp = pk_str >= regs[REG_CONFIRM_LEVEL] && pk_rise >= regs[REG_CONFIRM_RISE];
        if (!by_acc && !by_sharp) return EV_NONE;
        d = now - confirm_t - 32'(regs[REG_DT_WINDOW]);
        in_win = (d == 0) || d[31];
        confirm_t = now;
        if (awaiting && in_win) begin
          awaiting = 0;
          return EV_DOUBLE;
        end
        awaiting = 1;
        return EV_NONE;
      end
      if (!t_neg(now, cand_t, 32'(TAP_MAX_MS))) begin
        cand = 0; awaiting = 0; rejected = 1;
      end
      return EV_NONE;
    end
    if (awaiting && !t_neg(now, confirm_t, 32'(regs[REG_DT_WINDOW]))) begin
      awaiting = 0;
      return EV_SINGLE;
    end
    if (str >= {3'b0, regs[REG_START_LEVEL]}) begin
      cand = 1; cand_t = now;
      pk_str = s16; pk_acc = dyn; pk_rise = rise;
    end
    return EV_NONE;
  endfunction

  function automatic tap_result_t predict_tap(sample_t s);
    tap_result_t res;
    logic [33:0] sum;
    logic [31:0] s32;
    logic [16:0] base, dyn;
    sum = axis_sq(s.gx, regs[REG_OFF_X]) + axis_sq(s.gy, regs[REG_OFF_Y])
        + axis_sq(s.gz, regs[REG_OFF_Z]);
    s32 = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    res.gmag = isqrt(s32);
    base = {1'b0, baseline};
    dyn = ({1'b0, s.acc} > base) ? {1'b0, s.acc} - base : base - {1'b0, s.acc};
    if (dyn < {1'b0, TRACK_LIMIT}) begin
      if ({1'b0, s.acc} >= base) base = base + (({1'b0, s.acc} - base) >> 5);
      else base = base - (((base - {1'b0, s.acc}) + 17'd31) >> 5);
      baseline = base[15:0];
    end
    res.dyn = dyn[15:0];
    res.strength = {3'b0, res.gmag} + {1'b0, dyn[15:0], 2'b00};
    res.ev = EV_NONE;
    if (s.en) res.ev = run_tap(res.strength, res.dyn, s.tms);
    else clear_tap();
    res.busy = s.en && (cand || awaiting);
    return res;
  endfunction

  // accept, predict and check at the rising edge
  always @(posedge clk) begin
    tap_result_t e, a;
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("FAIL imu_tap_double_tap_detector");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      tap_exp_q.push_back(predict_tap(cur));
      acc_cnt++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      a.ev = tap_ev_t'(out_tdata[1:0]);
      a.busy = out_tdata[2];
      a.strength = out_tdata[21:3];
      a.gmag = out_tdata[37:22];
      a.dyn = out_tdata[53:38];
      if (tap_exp_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result item %h", out_tdata);
      end else begin
        e = tap_exp_q.pop_front();
        if (a.ev != e.ev || a.busy != e.busy || a.strength != e.strength ||
            a.gmag != e.gmag || a.dyn != e.dyn) begin
          errs++;
          if (errs <= 10)
            $display("mismatch ev %0d/%0d busy %0d/%0d str %0d/%0d gmag %0d/%0d dyn %0d/%0d",
                     e.ev, a.ev, e.busy, a.busy, e.strength, a.strength,
                     e.gmag, a.gmag, e.dyn, a.dyn);
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || seen_cnt != acc_cnt)) begin
      seen_cnt <= acc_cnt;
      if (sample_q.size() > 0 && (calm_lo || $urandom_range(99) >= 8)) begin
        cur = sample_q.pop_front();
        in_tdata <= {cur.tms, cur.acc, cur.gz, cur.gy, cur.gx};
        in_tuser <= cur.en;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_tready <= calm_hi || ($urandom_range(99) >= 8);
  end

  assign calm_lo = (cycle > 6000 && cycle < 14000);
  assign calm_hi = (cycle > 9000 && cycle < 17000);

  task automatic push(logic [15:0] gx, gy, gz, acc, logic [31:0] tms, logic en);
    sample_t s;
    s.gx = gx; s.gy = gy; s.gz = gz; s.acc = acc; s.tms = tms; s.en = en;
    sample_q.push_back(s);
    n_items++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || tap_exp_q.size() != 0);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    regs[idx] = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] ox, oy, oz, st, cl, cr, ca, win);
    write_reg(REG_OFF_X, ox);
    write_reg(REG_OFF_Y, oy);
    write_reg(REG_OFF_Z, oz);
    write_reg(REG_START_LEVEL, st);
    write_reg(REG_CONFIRM_LEVEL, cl);
    write_reg(REG_CONFIRM_RISE, cr);
    write_reg(REG_CONFIRM_ACCEL, ca);
    write_reg(REG_DT_WINDOW, win);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] c, int span);
    return c + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  task automatic quiet(int n, int dt_lo, int dt_hi);
    repeat (n) begin
      t_now += $urandom_range(dt_lo, dt_hi);
      push(jitter(regs[REG_OFF_X], 30), jitter(regs[REG_OFF_Y], 30),
           jitter(regs[REG_OFF_Z], 30), jitter(16'd1000, 12), t_now,
           $urandom_range(99) >= 3);
    end
  endtask

  task automatic burst(int len, int dt_hi);
    repeat (len) begin
      t_now += $urandom_range(1, dt_hi);
      push(jitter(regs[REG_OFF_X], $urandom_range(0, 3000)),
           jitter(regs[REG_OFF_Y], $urandom_range(0, 1500)),
           jitter(regs[REG_OFF_Z], $urandom_range(0, 800)),
           jitter(16'd1000, $urandom_range(0, 700)), t_now, 1'b1);
    end
  endtask

  task automatic tap_seq();
    int r;
    r = $urandom_range(99);
    quiet($urandom_range(1, 5), 2, 15);
    // long bursts can run past the candidate time limit
    burst((r < 12) ? $urandom_range(8, 14) : $urandom_range(1, 4), (r < 12) ? 15 : 25);
    quiet($urandom_range(1, 3), 2, 15);
    if (r >= 40) begin
      burst($urandom_range(1, 4), 25);
      quiet($urandom_range(1, 3), 2, 30);
    end
    if ($urandom_range(1) == 1) quiet(1, 100, 900);
  endtask

  task automatic noise(int n);
    repeat (n)
      push(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
           1'($urandom));
  endtask

  task automatic random_part(int n);
    int stop;
    stop = n_items + n;
    while (n_items < stop) begin
      if ($urandom_range(99) < 82) tap_seq();
      else noise($urandom_range(1, 3));
    end
  endtask

  initial begin
    regs[REG_OFF_X] = 16'd0;
    regs[REG_OFF_Y] = 16'd0;
    regs[REG_OFF_Z] = 16'd0;
    regs[REG_START_LEVEL] = RESET_START_LEVEL;
    regs[REG_CONFIRM_LEVEL] = RESET_CONFIRM_LEVEL;
    regs[REG_CONFIRM_RISE] = RESET_CONFIRM_RISE;
    regs[REG_CONFIRM_ACCEL] = RESET_CONFIRM_ACCEL;
    regs[REG_DT_WINDOW] = RESET_DT_WINDOW;
    baseline = RESET_BASELINE;
    cand_t = '0;
    confirm_t = '0;
    clear_tap();
    t_now = 32'd100;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // field extremes, then a clean double tap, then a clean single tap
    push(16'h8000, 16'h8000, 16'h8000, 16'd0, 32'd0, 1'b1);
    push(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    push(16'h0000, 16'h0000, 16'h0000, 16'd1000, 32'd10, 1'b0);
    push(16'hFFFF, 16'h0001, 16'h8000, 16'd1119, 32'd20, 1'b1);
    push(16'h0000, 16'h0000, 16'h0000, 16'd880, 32'd30, 1'b1);
    quiet(2, 5, 5);
    push(16'd800, 16'd0, 16'd0, 16'd1300, t_now + 5, 1'b1);
    push(16'd0, 16'd0, 16'd0, 16'd1000, t_now + 15, 1'b1);
    t_now += 100;
    push(16'd900, 16'd0, 16'd0, 16'd1400, t_now, 1'b1);
    push(16'd0, 16'd0, 16'd0, 16'd1000, t_now + 10, 1'b1);
    t_now += 300;
    push(16'd900, 16'd0, 16'd0, 16'd1400, t_now, 1'b1);
    push(16'd0, 16'd0, 16'd0, 16'd1000, t_now + 10, 1'b1);
    t_now += 800;
    quiet(2, 300, 400);
    random_part(220);
    wait_drained();

    write_all(jitter(16'd0, 300), jitter(16'd0, 300), jitter(16'd0, 300),
              16'($urandom_range(300, 700)), 16'($urandom_range(600, 1500)),
              16'($urandom_range(100, 600)), 16'($urandom_range(60, 300)),
              16'($urandom_range(200, 900)));
    random_part(230);
    wait_drained();

    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_part(180);
    wait_drained();

    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF);
    random_part(120);
    wait_drained();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    noise(300);
    wait_drained();

    // timestamps crossing the wrap point
    write_all(jitter(16'd0, 100), jitter(16'd0, 100), jitter(16'd0, 100), 16'd400, 16'd800,
              16'd250, 16'd100, 16'd700);
    t_now = 32'hFFFF_F000;
    random_part(300);
    wait_drained();

    repeat (40) @(posedge clk);
    if (errs == 0 && tap_exp_q.size() == 0) begin
      $display("PASS imu_tap_double_tap_detector");
    end else begin
      $display("FAIL imu_tap_double_tap_detector");
    end
    $finish;
  end
endmodule
`default_nettype wire

[imu_tap_double_tap_detector.f]
rtl/core/itd_pkg.sv
rtl/core/itd_front.sv
rtl/core/itd_queue.sv
rtl/core/itd_back.sv
rtl/core/imu_tap_double_tap_detector.sv
rtl/core/itd_checker.sv
dv/testbench.sv
